[sv/sli_pkg.sv]
`timescale 1ns / 1ps

package sli_pkg;

  // Number of cells in the sorted chain.
  localparam int CAPACITY = 16;
  // Width of the internal fill counter, wide enough to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Fixed width of the data values.
  localparam int DATA_W = 32;
  // Fixed width of the count field in a result beat.
  localparam int COUNT_FIELD_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_HEAD   = 2'd1,
    CMD_TAIL   = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    command_t                   command;
    logic signed [DATA_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   removed_value;
    logic                       removed_valid;
    status_t                    status;
    logic [COUNT_FIELD_W-1:0]   count;
  } res_t;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;      // open a slot at the insert point and shift the tail right
    logic shift_left;  // every cell but the last takes its right neighbor's value
  } cell_ctrl_t;

endpackage

[sv/sorted_list_insert_remove.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Beat
// cmd      in         cmd_valid / cmd_ready  sli_pkg::cmd_t (command, value)
// res      out        res_valid / res_ready  sli_pkg::res_t (removed_value, removed_valid,
//                                            status, count)
//
// For each command beat, all cells compare against the new value in parallel and
// shift on the edge that accepts it, and the result beat is registered.
// A new command is taken while the previous result is being taken, so the
// sustained rate is one beat per cycle while res_ready stays high.
// Reset clears the fill count and the result valid flag; cell contents are not reset.
// When res_ready is low with a result waiting, cmd_ready drops until it is taken.

module sorted_list_insert_remove (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  sli_pkg::cmd_t  cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output sli_pkg::res_t  res
);

  localparam int N = sli_pkg::CAPACITY;

  logic [sli_pkg::CNT_W-1:0]          count;
  logic [sli_pkg::CNT_W-1:0]          count_next;
  logic                               accept;
  sli_pkg::cell_ctrl_t                ctrl;
  sli_pkg::res_t                      res_next;
  logic [N:0]                         occ;
  logic [N-1:0]                       less;
  logic signed [sli_pkg::DATA_W-1:0]  cell_value [N];
  logic signed [sli_pkg::DATA_W-1:0]  tail_value;

  assign cmd_ready = !res_valid || res_ready;
  assign accept    = cmd_valid && cmd_ready;

  // Occupancy of each cell decoded from the fill count; one past the end is empty.
  for (genvar i = 0; i < N; i++) begin : g_occ
    assign occ[i] = sli_pkg::CNT_W'(i) < count;
  end
  assign occ[N] = 1'b0;

  // The chain of cells, each linked to its left and right neighbors.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [sli_pkg::DATA_W-1:0] lv;
    logic signed [sli_pkg::DATA_W-1:0] rv;
    logic                              ll;
    if (i == 0) begin : g_first
      assign lv = cmd.value;
      assign ll = 1'b1;
    end else begin : g_mid
      assign lv = cell_value[i-1];
      assign ll = less[i-1];
    end
    if (i == N - 1) begin : g_last
      assign rv = cell_value[i];
    end else begin : g_inner
      assign rv = cell_value[i+1];
    end
    sli_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .ins_value   (cmd.value),
      .left_value  (lv),
      .left_less   (ll),
      .right_value (rv),
      .occupied    (occ[i]),
      .value       (cell_value[i]),
      .less        (less[i])
    );
  end

  // The last occupied cell is the one whose right neighbor is empty.
  always_comb begin
    tail_value = '0;
    for (int i = 0; i < N; i++) begin
      if (occ[i] && !occ[i+1]) begin
        tail_value = tail_value | cell_value[i];
      end
    end
  end

  // Command decode, chain control and result beat.
  always_comb begin
    ctrl                   = '0;
    count_next             = count;
    res_next.removed_value = '0;
    res_next.removed_valid = 1'b0;
    res_next.status        = sli_pkg::ST_OK;
    case (cmd.command)
      sli_pkg::CMD_INSERT: begin
        if (count == sli_pkg::CNT_W'(N)) begin
          res_next.status = sli_pkg::ST_FULL;
        end else begin
          ctrl.insert = accept;
          count_next  = count + 1'b1;
        end
      end
      sli_pkg::CMD_HEAD: begin
        if (count == '0) begin
          res_next.status = sli_pkg::ST_EMPTY;
        end else begin
          ctrl.shift_left        = accept;
          count_next             = count - 1'b1;
          res_next.removed_value = cell_value[0];
          res_next.removed_valid = 1'b1;
        end
      end
      sli_pkg::CMD_TAIL: begin
        if (count == '0) begin
          res_next.status = sli_pkg::ST_EMPTY;
        end else begin
          count_next             = count - 1'b1;
          res_next.removed_value = tail_value;
          res_next.removed_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res_next.count = sli_pkg::COUNT_FIELD_W'(count_next);
  end

  // Fill count and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else if (accept) begin
      count     <= count_next;
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  // The fill count never passes the number of cells.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= sli_pkg::CNT_W'(N))
    else $error("fill count beyond capacity");

  // An accepted command always leaves a result beat waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("no result after an accepted command");

  // A removed value is reported only together with an ok status.
  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.removed_valid) |-> (res.status == sli_pkg::ST_OK))
    else $error("removed value with a non-ok status");

  // A successful removal lowers the fill count by exactly one.
  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (accept && res_next.removed_valid) |=> (count == $past(count) - 1'b1))
    else $error("removal did not lower the fill count by one");

endmodule

[sv/sli_cell.sv]
`timescale 1ns / 1ps

module sli_cell (
  input  logic                              clk,
  input  sli_pkg::cell_ctrl_t               ctrl,
  input  logic signed [sli_pkg::DATA_W-1:0] ins_value,
  input  logic signed [sli_pkg::DATA_W-1:0] left_value,
  input  logic                              left_less,
  input  logic signed [sli_pkg::DATA_W-1:0] right_value,
  input  logic                              occupied,
  output logic signed [sli_pkg::DATA_W-1:0] value,
  output logic                              less
);

  // This cell stays put on insert when it holds a value smaller than the new one.
  assign less = occupied && (value < ins_value);

  // Take the new value at the insert point, the left neighbor's value past it,
  // or the right neighbor's value when the head is removed.
  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (!less) begin
        value <= left_less ? ins_value : left_value;
      end
    end else if (ctrl.shift_left) begin
      value <= right_value;
    end
  end

endmodule
